### rtl/ius_pkg.sv
// Shared types, constants and helper functions of the interpolating upsampler.
// No dependencies; every other file of the block imports this package.
package ius_pkg;

    // Largest number of output frames per source sample.
    localparam int MAX_FACTOR = 64;
    localparam int FACTOR_W   = $clog2(MAX_FACTOR + 1);
    localparam int REM_W      = $clog2(MAX_FACTOR);

    // Fixed widths of the sample path and the configuration port.
    localparam int SAMPLE_W   = 16;
    localparam int CFG_FACT_W = 7;
    localparam int CFG_RES_W  = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Divider retires this many quotient bits per cycle.
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = SAMPLE_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_XOR    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_FACT_W-1:0] FACTOR_RESET = 7'd6;
    localparam logic [CFG_RES_W-1:0]  RES_RESET    = 5'd16;
    localparam logic [SAMPLE_W-1:0]   XOR_RESET    = 16'h0000;

    // Crush is active only for resolutions 1 through 15.
    localparam logic [CFG_RES_W-1:0] RES_MIN = 5'd1;
    localparam logic [CFG_RES_W-1:0] RES_MAX = 5'd15;

    // Configuration register set.
    typedef struct packed {
        logic [CFG_FACT_W-1:0] upsample_factor;
        logic [CFG_RES_W-1:0]  resolution_bits;
        logic [SAMPLE_W-1:0]   xor_pattern;
    } cfg_t;

    // One queued run: start value, per-frame step and frame count.
    typedef struct packed {
        logic [SAMPLE_W-1:0] prev;
        logic [SAMPLE_W-1:0] step;
        logic [FACTOR_W-1:0] factor;
    } run_t;

    // Queue control driven by the front part.
    typedef struct packed {
        logic push;
    } q_ctrl_t;

    // Factor zero acts as one; large factors saturate.
    function automatic logic [FACTOR_W-1:0] eff_factor(input logic [CFG_FACT_W-1:0] f);
        logic [FACTOR_W-1:0] r;
        if (f == '0)
        begin
            r = FACTOR_W'(1);
        end
        else if (32'(f) > MAX_FACTOR)
        begin
            r = FACTOR_W'(MAX_FACTOR);
        end
        else
        begin
            r = FACTOR_W'(f);
        end
        return r;
    endfunction

    // Clear low bits as the resolution asks, then apply the XOR pattern.
    function automatic logic [SAMPLE_W-1:0] crush(input logic [SAMPLE_W-1:0] v,
                                                  input logic [CFG_RES_W-1:0] res,
                                                  input logic [SAMPLE_W-1:0] pat);
        logic [SAMPLE_W-1:0]  m;
        logic [CFG_RES_W-1:0] clr;
        m   = v;
        clr = RES_MAX - res;
        if (res >= RES_MIN && res <= RES_MAX)
        begin
            m = v & ({SAMPLE_W{1'b1}} << clr);
        end
        return m ^ pat;
    endfunction

endpackage

### rtl/interpolating_upsampler_bitcrusher_top.sv
// Top level of the interpolating upsampler with bit crusher: configuration
// registers, front divider, run queue and frame generator. Uses ius_pkg.
//
//   Beat     | Handshake                   | Payload
//   ---------+-----------------------------+-------------------------------
//   sample   | sample_valid / sample_stall | source_sample
//   frame    | frame_valid / frame_stall   | stereo_frame, last_of_run
//   config   | cfg_we                      | cfg_index, cfg_data
//
// A source sample is accepted, divided in the radix-16 divider and pushed to
// the run queue; the next one is taken no earlier than that push. The back part
// sends F frames (F = effective factor), one per cycle while not stalled.
// A two-entry run queue lets the divider run ahead while frames are stalled.
// Reset is asynchronous; no clearing pass is needed after it.
module interpolating_upsampler_bitcrusher_top
    import ius_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_W-1:0] source_sample,
    output logic                       frame_valid,
    input  logic                       frame_stall,
    output logic [2*SAMPLE_W-1:0]      stereo_frame,
    output logic                       last_of_run,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    cfg_t    cfg_reg;
    q_ctrl_t q_ctrl;
    run_t    wr_run;
    run_t    rd_run;
    logic    q_full;
    logic    rd_valid;
    logic    pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upsample_factor <= FACTOR_RESET;
            cfg_reg.resolution_bits <= RES_RESET;
            cfg_reg.xor_pattern     <= XOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_FACTOR: cfg_reg.upsample_factor <= cfg_data[CFG_FACT_W-1:0];
                CFG_IDX_RES:    cfg_reg.resolution_bits <= cfg_data[CFG_RES_W-1:0];
                CFG_IDX_XOR:    cfg_reg.xor_pattern     <= cfg_data[SAMPLE_W-1:0];
                default:        cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    ius_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .source_sample (source_sample),
        .cfg           (cfg_reg),
        .q_full        (q_full),
        .q_ctrl        (q_ctrl),
        .run           (wr_run)
    );

    ius_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_ctrl   (q_ctrl),
        .wr_run   (wr_run),
        .full     (q_full),
        .pop      (pop),
        .rd_valid (rd_valid),
        .rd_run   (rd_run)
    );

    ius_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .rd_valid     (rd_valid),
        .rd_run       (rd_run),
        .pop          (pop),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .stereo_frame (stereo_frame),
        .last_of_run  (last_of_run)
    );

endmodule

### rtl/ius_front.sv
// Front part: accepts source samples, tracks previous and current sample and
// divides their difference by the factor in an iterative divider. Uses ius_pkg.
module ius_front
    import ius_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_W-1:0] source_sample,
    input  cfg_t                       cfg,
    input  logic                       q_full,
    output q_ctrl_t                    q_ctrl,
    output run_t                       run
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t               state_reg;
    logic [SAMPLE_W-1:0]  prev_reg;
    logic [SAMPLE_W-1:0]  cur_reg;
    logic                 neg_reg;
    logic [SAMPLE_W-1:0]  quo_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [FACTOR_W-1:0]  fact_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic                 accept;
    logic                 push;
    logic [SAMPLE_W:0]    diff;
    logic [SAMPLE_W-1:0]  mag;
    logic [SAMPLE_W-1:0]  quo_next;
    logic [REM_W-1:0]     rem_next;
    logic [SAMPLE_W-1:0]  step;

    // Accept in idle, or while the finished run leaves for the queue.
    assign push         = (state_reg == ST_PUSH) && !q_full;
    assign sample_stall = !((state_reg == ST_IDLE) || push);
    assign accept       = sample_valid && !sample_stall;

    // Signed difference of the new and the current sample, and its magnitude.
    assign diff = {source_sample[SAMPLE_W-1], source_sample} - {cur_reg[SAMPLE_W-1], cur_reg};
    assign mag  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];

    // Restoring division, several quotient bits per cycle.
    always_comb
    begin
        logic [REM_W:0]      trial;
        logic [REM_W:0]      r;
        logic [SAMPLE_W-1:0] q;
        r = {1'b0, rem_reg};
        q = quo_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            trial = {r[REM_W-1:0], q[SAMPLE_W-1]};
            q     = {q[SAMPLE_W-2:0], 1'b0};
            if (trial >= (REM_W+1)'(fact_reg))
            begin
                r    = trial - (REM_W+1)'(fact_reg);
                q[0] = 1'b1;
            end
            else
            begin
                r = trial;
            end
        end
        rem_next = r[REM_W-1:0];
        quo_next = q;
    end

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign step = neg_reg ? SAMPLE_W'(-quo_reg) : quo_reg;

    assign q_ctrl.push = push;
    assign run.prev    = prev_reg;
    assign run.step    = step;
    assign run.factor  = fact_reg;

    // Sequencer and sample history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prev_reg  <= '0;
            cur_reg   <= '0;
            neg_reg   <= 1'b0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            fact_reg  <= FACTOR_W'(1);
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE, ST_PUSH:
                begin
                    if (accept)
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= source_sample;
                        neg_reg   <= diff[SAMPLE_W];
                        quo_reg   <= mag;
                        rem_reg   <= '0;
                        fact_reg  <= eff_factor(cfg.upsample_factor);
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                    else if (push)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                    if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                    begin
                        state_reg <= ST_PUSH;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/ius_fifo.sv
// Two-entry queue of interpolation runs between front and back parts.
// Uses run_t and q_ctrl_t from ius_pkg.
module ius_fifo
    import ius_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_ctrl_t q_ctrl,
    input  run_t    wr_run,
    output logic    full,
    input  logic    pop,
    output logic    rd_valid,
    output run_t    rd_run
);

    run_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_run   = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (q_ctrl.push)
        begin
            mem[wr_ptr_reg] <= wr_run;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (q_ctrl.push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (q_ctrl.push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !q_ctrl.push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/ius_back.sv
// Back part: walks each queued run one frame per cycle unless stalled, crushes
// the value and holds the stereo frame in an output register. Uses ius_pkg.
module ius_back
    import ius_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  rd_valid,
    input  run_t                  rd_run,
    output logic                  pop,
    output logic                  frame_valid,
    input  logic                  frame_stall,
    output logic [2*SAMPLE_W-1:0] stereo_frame,
    output logic                  last_of_run
);

    logic                  active_reg;
    logic [SAMPLE_W-1:0]   acc_reg;
    logic [SAMPLE_W-1:0]   step_reg;
    logic [FACTOR_W-1:0]   left_reg;
    logic                  out_valid_reg;
    logic [2*SAMPLE_W-1:0] frame_reg;
    logic                  last_reg;

    logic                  out_free;
    logic                  emit;
    logic                  final_frame;
    logic [SAMPLE_W-1:0]   crushed;

    // A frame leaves the run when the output register is free.
    assign out_free    = !out_valid_reg || !frame_stall;
    assign emit        = active_reg && out_free;
    assign final_frame = (left_reg == FACTOR_W'(1));
    assign pop         = rd_valid && (!active_reg || (emit && final_frame));
    assign crushed     = crush(acc_reg, cfg.resolution_bits, cfg.xor_pattern);

    assign frame_valid  = out_valid_reg;
    assign stereo_frame = frame_reg;
    assign last_of_run  = last_reg;

    // Run walker and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            acc_reg       <= '0;
            step_reg      <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
            frame_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= 1'b1;
                acc_reg    <= rd_run.prev;
                step_reg   <= rd_run.step;
                left_reg   <= rd_run.factor;
            end
            else if (emit)
            begin
                acc_reg    <= acc_reg + step_reg;
                left_reg   <= left_reg - FACTOR_W'(1);
                active_reg <= !final_frame;
            end

            if (out_free)
            begin
                out_valid_reg <= emit;
                if (emit)
                begin
                    frame_reg <= {crushed, crushed};
                    last_reg  <= final_frame;
                end
            end
        end
    end

endmodule

### dv/testbench.sv
// Self-checking testbench of the interpolating upsampler with bit crusher.
// It predicts every stereo frame of each accepted sample and checks it against
// the block's output. Needs ius_pkg and interpolating_upsampler_bitcrusher_top.
module testbench;
    import ius_pkg::*;

    localparam int IDLE_PERCENT  = 27;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 400;

    // One expected output frame.
    typedef struct {
        logic [2*SAMPLE_W-1:0] frame;
        logic                  last;
    } frame_exp_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] source_sample = '0;
    logic                       frame_valid;
    logic                       frame_stall = 1'b0;
    logic [2*SAMPLE_W-1:0]      stereo_frame;
    logic                       last_of_run;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    // Predictor copy of the registers and the sample history.
    logic [CFG_FACT_W-1:0]      factor_reg = FACTOR_RESET;
    logic [CFG_RES_W-1:0]       res_reg = RES_RESET;
    logic [SAMPLE_W-1:0]        xor_reg = XOR_RESET;
    logic signed [SAMPLE_W-1:0] prev_q = '0;
    logic signed [SAMPLE_W-1:0] cur_q = '0;
    int                         step_q = 0;

    frame_exp_t                 frames_due[$];
    frame_exp_t                 head_frame;
    logic signed [SAMPLE_W-1:0] last_sent = '0;
    bit                         calm = 1'b0;
    int                         error_count = 0;

    interpolating_upsampler_bitcrusher_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .source_sample(source_sample),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .stereo_frame (stereo_frame),
        .last_of_run  (last_of_run),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Free-running clock, period 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Generous limit on the whole run.
    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // True when a side should sit idle for this cycle.
    function automatic bit idle_roll();
        return !calm && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // The frame receiver stalls at random, except in calm stretches.
    always @(negedge clk)
    begin
        frame_stall <= idle_roll();
    end

    // Work out the frames that one source sample produces.
    task automatic predict_frames(input logic signed [SAMPLE_W-1:0] s);
        int                  f;
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W-1:0] keep;
        frame_exp_t          e;
        f = (factor_reg == '0) ? 1 : int'(factor_reg);
        if (f > MAX_FACTOR)
        begin
            f = MAX_FACTOR;
        end
        prev_q = cur_q;
        cur_q  = s;
        // Signed division truncates toward zero.
        step_q = (int'(cur_q) - int'(prev_q)) / f;
        for (int k = 0; k < f; k++)
        begin
            v = SAMPLE_W'(int'(prev_q) + step_q * k);
            if (res_reg >= RES_MIN && res_reg <= RES_MAX)
            begin
                keep = '1;
                keep = keep << (RES_MAX - res_reg);
                v    = v & keep;
            end
            v       = v ^ xor_reg;
            e.frame = {v, v};
            e.last  = (k == f - 1);
            frames_due.push_back(e);
        end
    endtask

    // Predict on each accepted sample beat, then check each accepted frame beat.
    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
        begin
            predict_frames(source_sample);
        end
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (frames_due.size() == 0)
            begin
                $error("unexpected frame: stereo_frame %h last_of_run %b",
                       stereo_frame, last_of_run);
                error_count++;
            end
            else
            begin
                head_frame = frames_due.pop_front();
                if (stereo_frame !== head_frame.frame)
                begin
                    $error("stereo_frame: expected %h, actual %h",
                           head_frame.frame, stereo_frame);
                    error_count++;
                end
                if (last_of_run !== head_frame.last)
                begin
                    $error("last_of_run: expected %b, actual %b",
                           head_frame.last, last_of_run);
                    error_count++;
                end
            end
        end
    end

    // Send one source sample and return once its beat is accepted.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        @(negedge clk);
        while (idle_roll())
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid  <= 1'b1;
        source_sample <= s;
        last_sent      = s;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted frame has come out.
    task automatic wait_idle();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (frames_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_IDX_FACTOR: factor_reg = data[CFG_FACT_W-1:0];
            CFG_IDX_RES:    res_reg    = data[CFG_RES_W-1:0];
            CFG_IDX_XOR:    xor_reg    = data[SAMPLE_W-1:0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int factor, input int res, input int pattern);
        write_reg(CFG_IDX_FACTOR, CFG_DATA_W'(factor));
        write_reg(CFG_IDX_RES, CFG_DATA_W'(res));
        write_reg(CFG_IDX_XOR, CFG_DATA_W'(pattern));
    endtask

    // Reset values: factor 6, no crush, no pattern, with full-scale jumps.
    task automatic test_default_config();
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        wait_idle();
    endtask

    // Factor zero acts as one, and factors above the maximum saturate.
    task automatic test_factor_limits();
        int factors[5] = '{0, 1, MAX_FACTOR, MAX_FACTOR + 1, 127};
        foreach (factors[i])
        begin
            set_config(factors[i], 16, 0);
            send_sample(16'sh8000);
            send_sample(16'sh7fff);
            wait_idle();
        end
    endtask

    // Resolution below, inside and above the crush range, with patterns.
    task automatic test_bit_crush();
        int res_list[7] = '{0, 1, 7, 14, 15, 16, 31};
        int pat_list[7] = '{16'hffff, 16'h0000, 16'ha5a5, 16'h5a5a, 16'h8001, 16'hffff, 16'h1234};
        foreach (res_list[i])
        begin
            set_config(5, res_list[i], pat_list[i]);
            send_sample((i % 2 == 0) ? 16'sh7fff : 16'sh8000);
            wait_idle();
        end
    endtask

    // Random samples: random jumps, small steps from the last sample, full-scale hits and repeats.
    function automatic logic signed [SAMPLE_W-1:0] next_sample();
        int mode;
        mode = $urandom_range(9);
        case (mode)
            0, 1, 2, 3: return SAMPLE_W'($urandom);
            4, 5, 6:    return last_sent + SAMPLE_W'($urandom_range(1024) - 512);
            7:          return 16'sh7fff;
            8:          return 16'sh8000;
            default:    return last_sent;
        endcase
    endfunction

    // Pick a factor, mostly small so the run stays short.
    function automatic int pick_factor();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
        begin
            return $urandom_range(8);
        end
        else if (roll < 90)
        begin
            return $urandom_range(MAX_FACTOR, 9);
        end
        return $urandom_range(127, MAX_FACTOR + 1);
    endfunction

    // Phases of random settings and random samples; one phase runs without idling.
    task automatic test_random_phases();
        int sent;
        int phase_len;
        int phase;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_config(pick_factor(), $urandom_range(31), $urandom_range(16'hffff));
            calm      = (phase == 2);
            phase_len = $urandom_range(60, 20);
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                send_sample(next_sample());
                sent++;
            end
            wait_idle();
            calm = 1'b0;
            phase++;
        end
    endtask

    // Reset once, run every test in turn, then report.
    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_default_config();
        test_factor_limits();
        test_bit_crush();
        test_random_phases();
        wait_idle();
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
